// ===== design/sitoa_pkg.sv =====
package sitoa_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;

    // Output word: text_char [5:0], run_length [9:6], zero fill up to a whole byte.
    localparam int CHAR_W      = 6;
    localparam int LEN_W       = 4;
    localparam int OUT_TDATA_W = ((CHAR_W + LEN_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    // Decimal digits needed for any unsigned value of the given width:
    // floor(bits * log10(2)) + 1, with log10(2) taken as 1233 / 4096.
    function automatic int dec_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

// ===== design/signed_int_to_decimal_ascii_core.sv =====
// Signed integer to decimal ASCII text.
//
// Input channel s_axis: one word per value, the two's complement integer in
// the low VALUE_BITS bits of tdata. Output channel m_axis: one word per
// character, '-' first for negative values, then the digits from most to
// least significant, no leading zeros ("0" for zero). Every word carries the
// run length (masked to 4 bits) and tlast marks the final character.
//
// Sequence: after a value is accepted the shift-and-adjust BCD converter
// shifts the value in bit by bit, a leading-zero trim drops zero digits one
// at a time and keeps at least one, then one character leaves per cycle
// while the receiver keeps up. The single converter sets the rate;
// s_axis_tready is high only when the sequencer is idle, so a new value is
// taken only after the last character of the previous one has been loaded
// into the output register.
//
// Reset clears the sequencer and the output valid; no word is in flight.
// When the receiver stalls, the output register holds the current character
// and the sequencer waits; nothing is dropped.
module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_BITS = sitoa_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: value [VALUE_BITS-1:0], zero fill to a whole byte
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: text_char [5:0], run_length [9:6], zero fill above
    output logic [sitoa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int NDIG   = sitoa_pkg::dec_digits(VALUE_BITS);
    localparam int BCD_W  = 4 * NDIG;
    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int NDIG_W = $clog2(NDIG + 1);
    localparam int TOT_W  = $clog2(NDIG + 2);
    localparam int CHAR_W = sitoa_pkg::CHAR_W;
    localparam int LEN_W  = sitoa_pkg::LEN_W;

    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(VALUE_BITS - 1);
    localparam logic [NDIG_W-1:0] NDIG_FULL = NDIG_W'(NDIG);
    localparam logic [NDIG_W-1:0] NDIG_ONE  = NDIG_W'(1);

    // Sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_TRIM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NDIG_W-1:0]     ndig_reg, ndig_next;
    logic                  neg_reg, neg_next;
    logic                  sign_pend_reg, sign_pend_next;
    logic [TOT_W-1:0]      total_reg, total_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic                  out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;
    logic                  out_free;
    logic                  in_fire;
    logic [TOT_W+LEN_W-1:0] total_ext;

    assign raw       = s_axis_tdata[VALUE_BITS-1:0];
    assign mag       = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign total_ext = {{LEN_W{1'b0}}, total_reg};

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        ndig_next      = ndig_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    bin_next   = mag;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    neg_next   = raw[VALUE_BITS-1];
                    ndig_next  = NDIG_FULL;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                // Drop one leading zero digit a cycle, keep at least one.
                if (ndig_reg != NDIG_ONE && top_digit == 4'd0)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end
                else
                begin
                    total_next     = TOT_W'(ndig_reg) + TOT_W'(neg_reg);
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = total_ext[LEN_W-1:0];
                    if (sign_pend_reg)
                    begin
                        out_char_next  = sitoa_pkg::CH_MINUS;
                        out_last_next  = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        out_char_next = sitoa_pkg::CH_ZERO + CHAR_W'(top_digit);
                        out_last_next = (ndig_reg == NDIG_ONE);
                        bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                        ndig_next     = ndig_reg - NDIG_W'(1);
                        if (ndig_reg == NDIG_ONE)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_pend_reg <= sign_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        ndig_reg     <= ndig_next;
        neg_reg      <= neg_next;
        total_reg    <= total_next;
        out_char_reg <= out_char_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(sitoa_pkg::OUT_TDATA_W - CHAR_W - LEN_W){1'b0}},
                            out_len_reg, out_char_reg};

    // Emitted characters are always '-' or a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_char_reg == sitoa_pkg::CH_MINUS) ||
                          (out_char_reg >= sitoa_pkg::CH_ZERO &&
                           out_char_reg <= sitoa_pkg::CH_ZERO + CHAR_W'(9)))
        else $error("character out of range");

    // A run never ends on the sign.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> out_char_reg != sitoa_pkg::CH_MINUS)
        else $error("run ends on sign");

    // An accepted value starts the conversion in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_CONV)
        else $error("conversion did not start");

    // The digit count never falls to zero while digits are pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIM || state_reg == ST_EMIT) |-> ndig_reg != '0)
        else $error("digit count underflow");

    // A pending sign only exists for negative values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && sign_pend_reg) |-> neg_reg)
        else $error("sign pending on non-negative value");

endmodule
